>>> hdl/wheel_sync_pid_trim_defines.svh
// ----------------------------------------------------------------------------
// wheel_sync_pid_trim_defines.svh
// Assertion macros shared by the wheel sync trim block.
// ----------------------------------------------------------------------------
`ifndef WHEEL_SYNC_PID_TRIM_DEFINES_SVH
`define WHEEL_SYNC_PID_TRIM_DEFINES_SVH

// Same-cycle implication, held off while reset is asserted.
`define WSP_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define WSP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/wsp_pkg.sv
// ----------------------------------------------------------------------------
// wsp_pkg
// Types, widths and constants shared by the wheel sync trim modules.
// ----------------------------------------------------------------------------
package wsp_pkg;

  // Parameter defaults.
  localparam int POS_W_DEF     = 32;
  localparam int VEL_W_DEF     = 13;
  localparam int GAIN_FRAC_DEF = 8;

  // Fixed field widths.
  localparam int POS_FIELD_W = 32;
  localparam int TGT_FIELD_W = 13;
  localparam int VEL_MAX_W   = 16;
  localparam int SPEED_W     = 9;
  localparam int PWM_W       = 9;
  localparam int ADJ_W       = 7;
  localparam int GAIN_W      = 16;
  localparam int MINPWM_W    = 8;
  localparam int SUM_W       = 32;
  localparam int INTEG_W     = 9;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int IN_TDATA_W  = 112;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_TUSER_W = 2;

  // Limits.
  localparam int INTEG_LIM  = 150;
  localparam int TRIM_LIM   = 50;
  localparam int PWM_MAX    = 255;
  localparam int TGT_THRESH = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_P  = 2'd0,
    CFG_GAIN_I  = 2'd1,
    CFG_GAIN_D  = 2'd2,
    CFG_MIN_PWM = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MUL_P = 2'd0,
    MUL_I = 2'd1,
    MUL_D = 2'd2
  } mul_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DELTA,
    ST_SUM,
    ST_INTEG,
    ST_MUL_P,
    ST_MUL_I,
    ST_MUL_D,
    ST_ACC,
    ST_TRIM,
    ST_SPLIT,
    ST_SCALE,
    ST_FINISH
  } ctrl_state_e;

  typedef struct packed {
    logic     in_ready;
    logic     capture;
    logic     delta;
    logic     sum;
    logic     integ;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     acc_load;
    logic     acc_add;
    logic     trim;
    logic     split;
    logic     scale;
    logic     finish;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

>>> hdl/wsp_ctrl.sv
// ----------------------------------------------------------------------------
// wsp_ctrl
// Sequencer that walks one control tick through the datapath.
// ----------------------------------------------------------------------------
module wsp_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  input  wsp_pkg::dp_status_t status_i,
  output wsp_pkg::dp_cmd_t    cmd_o
);

  wsp_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wsp_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      wsp_pkg::ST_IDLE:   if (s_tvalid_i) state_d = wsp_pkg::ST_DELTA;
      wsp_pkg::ST_DELTA:  state_d = wsp_pkg::ST_SUM;
      wsp_pkg::ST_SUM:    state_d = wsp_pkg::ST_INTEG;
      wsp_pkg::ST_INTEG:  state_d = wsp_pkg::ST_MUL_P;
      wsp_pkg::ST_MUL_P:  state_d = wsp_pkg::ST_MUL_I;
      wsp_pkg::ST_MUL_I:  state_d = wsp_pkg::ST_MUL_D;
      wsp_pkg::ST_MUL_D:  state_d = wsp_pkg::ST_ACC;
      wsp_pkg::ST_ACC:    state_d = wsp_pkg::ST_TRIM;
      wsp_pkg::ST_TRIM:   state_d = wsp_pkg::ST_SPLIT;
      wsp_pkg::ST_SPLIT:  state_d = wsp_pkg::ST_SCALE;
      wsp_pkg::ST_SCALE:  state_d = wsp_pkg::ST_FINISH;
      wsp_pkg::ST_FINISH: if (status_i.out_free) state_d = wsp_pkg::ST_IDLE;
      default:            state_d = wsp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.mul_sel = wsp_pkg::MUL_P;
    case (state_q)
      wsp_pkg::ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        cmd_o.capture  = s_tvalid_i;
      end
      wsp_pkg::ST_DELTA: cmd_o.delta = 1'b1;
      wsp_pkg::ST_SUM:   cmd_o.sum = 1'b1;
      wsp_pkg::ST_INTEG: cmd_o.integ = 1'b1;
      wsp_pkg::ST_MUL_P: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = wsp_pkg::MUL_P;
      end
      wsp_pkg::ST_MUL_I: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_sel  = wsp_pkg::MUL_I;
        cmd_o.acc_load = 1'b1;
      end
      wsp_pkg::ST_MUL_D: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = wsp_pkg::MUL_D;
        cmd_o.acc_add = 1'b1;
      end
      wsp_pkg::ST_ACC:    cmd_o.acc_add = 1'b1;
      wsp_pkg::ST_TRIM:   cmd_o.trim = 1'b1;
      wsp_pkg::ST_SPLIT:  cmd_o.split = 1'b1;
      wsp_pkg::ST_SCALE:  cmd_o.scale = 1'b1;
      wsp_pkg::ST_FINISH: cmd_o.finish = status_i.out_free;
      default: ;
    endcase
  end

endmodule

>>> hdl/wsp_datapath.sv
// ----------------------------------------------------------------------------
// wsp_datapath
// Registers, PID arithmetic with one shared multiplier, trim split,
// deadband shaping and the output register of the wheel sync trim.
// ----------------------------------------------------------------------------
module wsp_datapath #(
  parameter int POS_WIDTH = wsp_pkg::POS_W_DEF,
  parameter int VEL_WIDTH = wsp_pkg::VEL_W_DEF,
  parameter int GAIN_FRAC = wsp_pkg::GAIN_FRAC_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [wsp_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [wsp_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic [wsp_pkg::IN_TDATA_W-1:0]     s_tdata_i,
  input  logic                               m_tready_i,
  input  wsp_pkg::dp_cmd_t                   cmd_i,
  output wsp_pkg::dp_status_t                status_o,
  output logic                               m_tvalid_o,
  output logic [wsp_pkg::OUT_TDATA_W-1:0]    m_tdata_o,
  output logic [wsp_pkg::OUT_TUSER_W-1:0]    m_tuser_o
);

  localparam int P       = POS_WIDTH;
  localparam int V       = VEL_WIDTH;
  localparam int SUM_W   = wsp_pkg::SUM_W;
  localparam int EXT_W   = ((SUM_W > P + 1) ? SUM_W : P + 1) + 1;
  localparam int MOP_W   = SUM_W + 1;
  localparam int GAIN_W  = wsp_pkg::GAIN_W;
  localparam int PROD_W  = GAIN_W + MOP_W;
  localparam int ACC_W   = PROD_W + 2;
  localparam int INTEG_W = wsp_pkg::INTEG_W;
  localparam int ADJ_W   = wsp_pkg::ADJ_W;
  localparam int SPEED_W = wsp_pkg::SPEED_W;
  localparam int CMD_W   = SPEED_W + 1;
  localparam int MAG_W   = SPEED_W;
  localparam int MIN_W   = wsp_pkg::MINPWM_W;
  localparam int SCL_W   = MAG_W + MIN_W;
  localparam int PWM_W   = wsp_pkg::PWM_W;
  localparam int PF_W    = wsp_pkg::POS_FIELD_W;
  localparam int TF_W    = wsp_pkg::TGT_FIELD_W;
  localparam int VM_W    = wsp_pkg::VEL_MAX_W;

  // Input beat layout.
  localparam int OFS_PL = 0;
  localparam int OFS_PR = OFS_PL + PF_W;
  localparam int OFS_TL = OFS_PR + PF_W;
  localparam int OFS_TR = OFS_TL + TF_W;
  localparam int OFS_SL = OFS_TR + TF_W;
  localparam int OFS_SR = OFS_SL + SPEED_W;
  localparam int OUT_PAD_W = wsp_pkg::OUT_TDATA_W - (2 * PWM_W + ADJ_W);

  localparam logic signed [SUM_W:0]   INT_HI   = (SUM_W + 1)'(wsp_pkg::INTEG_LIM);
  localparam logic signed [SUM_W:0]   INT_LO   = -INT_HI;
  localparam logic signed [ACC_W-1:0] TRIM_HI  = ACC_W'(wsp_pkg::TRIM_LIM);
  localparam logic signed [ACC_W-1:0] TRIM_LO  = -TRIM_HI;
  localparam logic signed [ACC_W-1:0] RND_BIAS = ACC_W'((1 << GAIN_FRAC) - 1);
  localparam logic signed [V-1:0]     THR_POS  = V'(wsp_pkg::TGT_THRESH);
  localparam logic signed [V-1:0]     THR_NEG  = -THR_POS;
  localparam logic signed [CMD_W-1:0] CMD_ONE  = CMD_W'(1);
  localparam logic [MIN_W-1:0]        PWM_TOP  = MIN_W'(wsp_pkg::PWM_MAX);

  // Configuration.
  logic signed [GAIN_W-1:0] gain_p_q, gain_i_q, gain_d_q;
  logic [MIN_W-1:0]         min_pwm_q;

  // Captured beat.
  logic [P-1:0]               pl_q, pr_q;
  logic signed [V-1:0]        tl_q, tr_q;
  logic signed [SPEED_W-1:0]  sl_q, sr_q;

  // Loop state.
  logic [P-1:0]               last_l_q, last_r_q;
  logic signed [V-1:0]        prev_tl_q, prev_tr_q;
  logic signed [SUM_W-1:0]    err_sum_q, prev_sum_q;
  logic signed [INTEG_W-1:0]  integ_q;

  // Working registers.
  logic                       active_q, straight_q;
  logic signed [P:0]          step_q;
  logic signed [MOP_W-1:0]    deriv_q;
  logic signed [PROD_W-1:0]   prod_q;
  logic signed [ACC_W-1:0]    acc_q;
  logic signed [ADJ_W-1:0]    adj_q;
  logic signed [CMD_W-1:0]    cmd_l_q, cmd_r_q;
  logic [MAG_W-1:0]           mag_l_q, mag_r_q;
  logic                       neg_l_q, neg_r_q;
  logic [SCL_W-1:0]           scl_l_q, scl_r_q;

  // Output register.
  logic                             out_valid_q;
  logic [wsp_pkg::OUT_TDATA_W-1:0]  out_data_q;
  logic [wsp_pkg::OUT_TUSER_W-1:0]  out_user_q;

  // Combinational values.
  logic [VM_W-1:0]            tl_ext, tr_ext;
  logic signed [P-1:0]        dl, dr;
  logic signed [P:0]          dl_w, dr_w, adl, adr, step_d;
  logic signed [V:0]          tsum;
  logic                       changed, nonzero, equal, opposite;
  logic signed [EXT_W-1:0]    sum_wide;
  logic [EXT_W-SUM_W:0]       sum_top;
  logic signed [SUM_W-1:0]    sum_sat;
  logic signed [SUM_W:0]      integ_wide;
  logic signed [INTEG_W-1:0]  integ_d;
  logic signed [GAIN_W-1:0]   mul_a;
  logic signed [MOP_W-1:0]    mul_b;
  logic signed [ACC_W-1:0]    biased, shifted;
  logic signed [ADJ_W-1:0]    adj_d, half, rest;
  logic signed [CMD_W-1:0]    trim_l, trim_r, pre_l, pre_r;
  logic signed [CMD_W-1:0]    abs_l, abs_r;
  logic [MIN_W-1:0]           span;
  logic [PWM_W-1:0]           pwm_l, pwm_r;

  // Floor division by 255 through a reciprocal and one correction step.
  function automatic logic [MAG_W-1:0] div255(input logic [SCL_W-1:0] x);
    logic [SCL_W+MIN_W-1:0] p;
    logic [MAG_W-1:0]       qe;
    logic [SCL_W-1:0]       e;
    logic [SCL_W-1:0]       r;
    p  = {x, {MIN_W{1'b0}}} + (SCL_W + MIN_W)'(x);
    qe = p[SCL_W+MIN_W-1:2*MIN_W];
    e  = {qe, {MIN_W{1'b0}}} - SCL_W'(qe);
    r  = x - e;
    return (r >= SCL_W'(wsp_pkg::PWM_MAX)) ? qe + MAG_W'(1) : qe;
  endfunction

  // A moving target forces at least one count of drive in its direction.
  function automatic logic signed [CMD_W-1:0] lock_sign(
    input logic signed [CMD_W-1:0] s,
    input logic signed [V-1:0]     t
  );
    logic signed [CMD_W-1:0] r;
    r = s;
    if (t > THR_POS) begin
      if (s < CMD_ONE) r = CMD_ONE;
    end else if (t < THR_NEG) begin
      if (s > -CMD_ONE) r = -CMD_ONE;
    end
    return r;
  endfunction

  // Affine deadband: nonzero magnitudes start at the floor and reach full scale.
  function automatic logic [PWM_W-1:0] shape(
    input logic [MIN_W-1:0] floor_v,
    input logic [MAG_W-1:0] mag,
    input logic [SCL_W-1:0] scl,
    input logic             neg
  );
    logic [MAG_W:0]   m;
    logic [MIN_W-1:0] m8;
    logic [PWM_W-1:0] r;
    m  = (MAG_W + 1)'(floor_v) + (MAG_W + 1)'(div255(scl));
    m8 = (m > (MAG_W + 1)'(wsp_pkg::PWM_MAX)) ? PWM_TOP : m[MIN_W-1:0];
    if (mag == '0) begin
      r = '0;
    end else if (neg) begin
      r = -PWM_W'(m8);
    end else begin
      r = PWM_W'(m8);
    end
    return r;
  endfunction

  // Deltas, target change and mode.
  always_comb begin
    tl_ext   = VM_W'(s_tdata_i[OFS_TL +: TF_W]);
    tr_ext   = VM_W'(s_tdata_i[OFS_TR +: TF_W]);
    dl       = $signed(pl_q - last_l_q);
    dr       = $signed(pr_q - last_r_q);
    dl_w     = (P + 1)'(dl);
    dr_w     = (P + 1)'(dr);
    adl      = dl_w[P] ? -dl_w : dl_w;
    adr      = dr_w[P] ? -dr_w : dr_w;
    tsum     = (V + 1)'(tl_q) + (V + 1)'(tr_q);
    changed  = (tl_q != prev_tl_q) || (tr_q != prev_tr_q);
    nonzero  = (tl_q != '0) && (tr_q != '0);
    equal    = (tl_q == tr_q);
    opposite = (tsum == '0);
    step_d   = equal ? (dl_w - dr_w) : (adl - adr);
  end

  // Saturating error sum and clamped integral.
  always_comb begin
    sum_wide = EXT_W'(err_sum_q) + EXT_W'(step_q);
    sum_top  = sum_wide[EXT_W-1:SUM_W-1];
    if ((&sum_top) || !(|sum_top)) begin
      sum_sat = sum_wide[SUM_W-1:0];
    end else if (sum_wide[EXT_W-1]) begin
      sum_sat = {1'b1, {(SUM_W - 1){1'b0}}};
    end else begin
      sum_sat = {1'b0, {(SUM_W - 1){1'b1}}};
    end
    integ_wide = (SUM_W + 1)'(integ_q) + (SUM_W + 1)'(err_sum_q);
    if (integ_wide > INT_HI) begin
      integ_d = INTEG_W'(INT_HI);
    end else if (integ_wide < INT_LO) begin
      integ_d = INTEG_W'(INT_LO);
    end else begin
      integ_d = integ_wide[INTEG_W-1:0];
    end
  end

  // Shared multiplier operands.
  always_comb begin
    case (cmd_i.mul_sel)
      wsp_pkg::MUL_P: begin
        mul_a = gain_p_q;
        mul_b = MOP_W'(err_sum_q);
      end
      wsp_pkg::MUL_I: begin
        mul_a = gain_i_q;
        mul_b = MOP_W'(integ_q);
      end
      default: begin
        mul_a = gain_d_q;
        mul_b = deriv_q;
      end
    endcase
  end

  // Scaling toward zero, clamp, and the split between the wheels.
  always_comb begin
    biased  = acc_q + (acc_q[ACC_W-1] ? RND_BIAS : '0);
    shifted = biased >>> GAIN_FRAC;
    if (!active_q) begin
      adj_d = '0;
    end else if (shifted > TRIM_HI) begin
      adj_d = ADJ_W'(TRIM_HI);
    end else if (shifted < TRIM_LO) begin
      adj_d = ADJ_W'(TRIM_LO);
    end else begin
      adj_d = shifted[ADJ_W-1:0];
    end
    half = $signed(adj_q + {{(ADJ_W - 1){1'b0}}, adj_q[ADJ_W-1]}) >>> 1;
    rest = adj_q - half;
    if (straight_q) begin
      trim_l = -CMD_W'(half);
      trim_r = CMD_W'(rest);
    end else begin
      trim_l = tl_q[V-1] ? CMD_W'(half) : -CMD_W'(half);
      trim_r = tr_q[V-1] ? -CMD_W'(rest) : CMD_W'(rest);
    end
    pre_l = lock_sign(CMD_W'(sl_q) + trim_l, tl_q);
    pre_r = lock_sign(CMD_W'(sr_q) + trim_r, tr_q);
    abs_l = cmd_l_q[CMD_W-1] ? -cmd_l_q : cmd_l_q;
    abs_r = cmd_r_q[CMD_W-1] ? -cmd_r_q : cmd_r_q;
    span  = PWM_TOP - min_pwm_q;
    pwm_l = shape(min_pwm_q, mag_l_q, scl_l_q, neg_l_q);
    pwm_r = shape(min_pwm_q, mag_r_q, scl_r_q, neg_r_q);
  end

  // Configuration, loop state and the output flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q    <= '0;
      gain_i_q    <= '0;
      gain_d_q    <= '0;
      min_pwm_q   <= '0;
      last_l_q    <= '0;
      last_r_q    <= '0;
      prev_tl_q   <= '0;
      prev_tr_q   <= '0;
      err_sum_q   <= '0;
      prev_sum_q  <= '0;
      integ_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (wsp_pkg::cfg_idx_e'(cfg_idx_i))
          wsp_pkg::CFG_GAIN_P:  gain_p_q  <= $signed(cfg_wdata_i[GAIN_W-1:0]);
          wsp_pkg::CFG_GAIN_I:  gain_i_q  <= $signed(cfg_wdata_i[GAIN_W-1:0]);
          wsp_pkg::CFG_GAIN_D:  gain_d_q  <= $signed(cfg_wdata_i[GAIN_W-1:0]);
          wsp_pkg::CFG_MIN_PWM: min_pwm_q <= cfg_wdata_i[MIN_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.delta) begin
        last_l_q <= pl_q;
        last_r_q <= pr_q;
        if (changed) begin
          err_sum_q  <= '0;
          prev_sum_q <= '0;
          integ_q    <= '0;
          prev_tl_q  <= tl_q;
          prev_tr_q  <= tr_q;
        end
      end
      if (cmd_i.sum && active_q) begin
        err_sum_q <= sum_sat;
      end
      if (cmd_i.integ && active_q) begin
        integ_q    <= integ_d;
        prev_sum_q <= err_sum_q;
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working and payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      pl_q <= s_tdata_i[OFS_PL +: P];
      pr_q <= s_tdata_i[OFS_PR +: P];
      tl_q <= $signed(tl_ext[V-1:0]);
      tr_q <= $signed(tr_ext[V-1:0]);
      sl_q <= $signed(s_tdata_i[OFS_SL +: SPEED_W]);
      sr_q <= $signed(s_tdata_i[OFS_SR +: SPEED_W]);
    end
    if (cmd_i.delta) begin
      active_q   <= nonzero && (equal || opposite);
      straight_q <= nonzero && equal;
      step_q     <= step_d;
    end
    if (cmd_i.integ) begin
      deriv_q <= MOP_W'(err_sum_q) - MOP_W'(prev_sum_q);
    end
    if (cmd_i.mul_en) begin
      prod_q <= mul_a * mul_b;
    end
    if (cmd_i.acc_load) begin
      acc_q <= ACC_W'(prod_q);
    end else if (cmd_i.acc_add) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
    if (cmd_i.trim) begin
      adj_q <= adj_d;
    end
    if (cmd_i.split) begin
      cmd_l_q <= pre_l;
      cmd_r_q <= pre_r;
    end
    if (cmd_i.scale) begin
      mag_l_q <= abs_l[MAG_W-1:0];
      mag_r_q <= abs_r[MAG_W-1:0];
      neg_l_q <= cmd_l_q[CMD_W-1];
      neg_r_q <= cmd_r_q[CMD_W-1];
      scl_l_q <= SCL_W'(span) * SCL_W'(abs_l[MAG_W-1:0]);
      scl_r_q <= SCL_W'(span) * SCL_W'(abs_r[MAG_W-1:0]);
    end
    if (cmd_i.finish) begin
      out_data_q <= {{OUT_PAD_W{1'b0}}, adj_q, pwm_r, pwm_l};
      out_user_q <= {straight_q, active_q};
    end
  end

  assign status_o.out_free = !out_valid_q || m_tready_i;
  assign m_tvalid_o        = out_valid_q;
  assign m_tdata_o         = out_data_q;
  assign m_tuser_o         = out_user_q;

endmodule

>>> hdl/wheel_sync_pid_trim.sv
// ----------------------------------------------------------------------------
// wheel_sync_pid_trim
// Left/right wheel synchronization trim for one control tick. Each input beat
// carries both encoder positions, both target velocities and both ramped
// speed commands; each one yields exactly one output beat with the two wheel
// drives, the applied trim and the mode flags. Between acceptance and a loaded
// output register the sequencer steps through the encoder deltas, the error
// sum and integral, the shared 16 x 33 bit multiplier that forms the three PID
// products one after another and accumulates them, and then scaling, split,
// deadband multiply and the divide by 255. The next beat is taken only in the
// idle step, so no new beat enters while a tick is in progress. A new beat is
// taken while the previous result still waits in the output register; the
// sequencer only holds in its last step when that register is still occupied.
// Gains and the deadband floor are to be written through the register port
// only while no tick is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`include "wheel_sync_pid_trim_defines.svh"

module wheel_sync_pid_trim #(
  parameter int POS_WIDTH = wsp_pkg::POS_W_DEF,
  parameter int VEL_WIDTH = wsp_pkg::VEL_W_DEF,
  parameter int GAIN_FRAC = wsp_pkg::GAIN_FRAC_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Register port: 0 gain_p, 1 gain_i, 2 gain_d, 3 min_pwm.
  input  logic                            cfg_we_i,
  input  logic [wsp_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [wsp_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // From bit 0 up: pos_left[31:0], pos_right[31:0], target_left[12:0],
  // target_right[12:0], speed_left[8:0], speed_right[8:0], zero fill.
  input  logic [wsp_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // From bit 0 up: pwm_left[8:0], pwm_right[8:0], sync_adjust[6:0], zero fill.
  output logic [wsp_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  // From bit 0 up: sync_active, straight_mode.
  output logic [wsp_pkg::OUT_TUSER_W-1:0] m_axis_tuser_o
);

  wsp_pkg::dp_cmd_t    dp_cmd;
  wsp_pkg::dp_status_t dp_status;
  logic                in_accept;

  // The sequencer owns the handshake on the input side; the datapath owns
  // the output register and reports whether it can take a new result.
  wsp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .status_i   (dp_status),
    .cmd_o      (dp_cmd)
  );

  wsp_datapath #(
    .POS_WIDTH (POS_WIDTH),
    .VEL_WIDTH (VEL_WIDTH),
    .GAIN_FRAC (GAIN_FRAC)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_tdata_i   (s_axis_tdata_i),
    .m_tready_i  (m_axis_tready_i),
    .cmd_i       (dp_cmd),
    .status_o    (dp_status),
    .m_tvalid_o  (m_axis_tvalid_o),
    .m_tdata_o   (m_axis_tdata_o),
    .m_tuser_o   (m_axis_tuser_o)
  );

  assign s_axis_tready_o = dp_cmd.in_ready;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;

  // An accepted beat starts a tick, so the input side closes next cycle.
  `WSP_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_accept, !s_axis_tready_o,
                   "input still ready right after a beat was accepted")

  // A result is only loaded when the output register is free.
  `WSP_ASSERT_NOW(a_load_when_free, clk_i, rst_ni, dp_cmd.finish,
                  !m_axis_tvalid_o || m_axis_tready_i,
                  "result loaded over a beat that was not taken")

  // Output valid only rises as the result of a sequencer load.
  `WSP_ASSERT_NOW(a_valid_from_load, clk_i, rst_ni, $rose(m_axis_tvalid_o),
                  $past(dp_cmd.finish), "output valid rose without a load")

endmodule
